@@ src/brf_pkg.sv @@
// ============================================================================
// brf_pkg
// Shared widths, command codes and the result record for the byte ring FIFO.
// ============================================================================
package brf_pkg;

    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int OCC_W  = 4;
    localparam int CAP_W  = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT_OVR = 3'd0;  // put, drop oldest when full
    localparam logic [CMD_W-1:0] CMD_PUT_TRY = 3'd1;  // put, refused when full
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // One result record on its way to the output register
    typedef struct packed {
        logic             valid;
        logic             status;   // 1 = refused
        logic             last;
        logic [OCC_W-1:0] occ;
        logic             use_ram;  // byte comes from the RAM read port
    } res_t;

endpackage

@@ src/byte_ring_fifo_with_peek.sv @@
// ============================================================================
// byte_ring_fifo_with_peek
// Byte FIFO on a ring of capacity + 1 slots with put, get, peek and clear.
// ============================================================================
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  s       | in        | s_tvalid/s_tready | s_tdata: cmd, write_byte, peek_count
//  m       | out       | m_tvalid/m_tready | m_tdata: read_byte, occupancy;
//          |           |                   | m_tuser: status; m_tlast: last
//  cfg     | in        | cfg_wen           | cfg_wdata: capacity (clears ring)
//
//  Put, get, clear: one item per cycle while s_tready is high; each result
//  passes through the RAM read register, then the output register.
//  Peek of N bytes: N reads on the single read port, one per cycle unless stalled.
//  s_tready is low while a peek is being read out or a stalled result fills
//  both result registers.
//  Reset: capacity 15, ring empty; RAM contents are not cleared.
//
module byte_ring_fifo_with_peek import brf_pkg::*; #(
    parameter int RING_SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CAP_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // cmd[2:0], write_byte[10:3], peek_count[14:11]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // read_byte[7:0], occupancy[11:8]
    output logic                m_tuser,   // status
    output logic                m_tlast
);

    localparam int PW = $clog2(RING_SLOTS);

    logic               ram_wen;
    logic [PW-1:0]      ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_ren;
    logic [PW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;
    res_t               s1_res;
    logic               s1_adv;
    logic [BYTE_W-1:0]  out_byte;
    logic [OCC_W-1:0]   out_occ;

    brf_ctrl #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tdata[2:0]),
        .write_byte (s_tdata[10:3]),
        .peek_count (s_tdata[14:11]),
        .ram_wen    (ram_wen),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_ren    (ram_ren),
        .ram_raddr  (ram_raddr),
        .s1_res     (s1_res),
        .s1_adv     (s1_adv)
    );

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_res     (s1_res),
        .ram_rdata  (ram_rdata),
        .s1_adv     (s1_adv),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_byte   (out_byte),
        .out_last   (m_tlast),
        .out_occ    (out_occ)
    );

    // Pack result payload, upper bits zero
    assign m_tdata = {4'b0000, out_occ, out_byte};

endmodule

@@ src/brf_ram.sv @@
// ============================================================================
// brf_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, output holds while ren is low
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/brf_ctrl.sv @@
// ============================================================================
// brf_ctrl
// Position registers, command decode, peek sequencer and the result stage
// that sits beside the RAM read register.
// ============================================================================
module brf_ctrl import brf_pkg::*; #(
    parameter int RING_SLOTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [CAP_W-1:0]                 cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [CMD_W-1:0]                 cmd,
    input  logic [BYTE_W-1:0]                write_byte,
    input  logic [CNT_W-1:0]                 peek_count,
    output logic                             ram_wen,
    output logic [$clog2(RING_SLOTS)-1:0]    ram_waddr,
    output logic [BYTE_W-1:0]                ram_wdata,
    output logic                             ram_ren,
    output logic [$clog2(RING_SLOTS)-1:0]    ram_raddr,
    output res_t                             s1_res,
    input  logic                             s1_adv
);

    localparam int PW      = $clog2(RING_SLOTS);
    localparam int MAX_CAP = RING_SLOTS - 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PEEK = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [PW-1:0]      rp_reg, rp_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    res_t               s1_reg;

    logic [PW-1:0]      eff_cap;
    logic               full;
    logic               empty;
    logic [OCC_W-1:0]   occ_now;
    logic               accept;
    logic               s1_free;
    logic               load;
    logic               new_status;
    logic               new_last;
    logic               new_use;

    // Next ring position, wraps after the effective capacity
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [PW-1:0] c);
        logic [PW-1:0] r;
        r = (p >= c) ? '0 : p + 1'b1;
        return r;
    endfunction

    // Stored byte count for a pair of positions
    function automatic logic [OCC_W-1:0] occ_fn(input logic [PW-1:0] w,
                                                input logic [PW-1:0] r,
                                                input logic [PW-1:0] c);
        logic [PW:0] we, re, ce, v;
        we = {1'b0, w};
        re = {1'b0, r};
        ce = {1'b0, c};
        if (adv(w, c) == r)
        begin
            v = ce;
        end
        else if (w >= r)
        begin
            v = we - re;
        end
        else
        begin
            v = ce + (PW+1)'(1) + we - re;
        end
        return OCC_W'(v);
    endfunction

    // Status of the ring as it stands
    assign eff_cap = (int'(cap_reg) > MAX_CAP) ? PW'(MAX_CAP) : PW'(cap_reg);
    assign full    = (adv(wp_reg, eff_cap) == rp_reg);
    assign empty   = (wp_reg == rp_reg);
    assign occ_now = occ_fn(wp_reg, rp_reg, eff_cap);

    assign s1_free  = !s1_reg.valid || s1_adv;
    assign in_ready = (state_reg == ST_IDLE) && s1_free;
    assign accept   = in_valid && in_ready;

    // Command decode and peek sequencing
    always_comb
    begin
        state_next = state_reg;
        cap_next   = cap_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        ram_wen    = 1'b0;
        ram_waddr  = wp_reg;
        ram_wdata  = write_byte;
        ram_ren    = 1'b0;
        ram_raddr  = rp_reg;
        load       = 1'b0;
        new_status = 1'b0;
        new_last   = 1'b1;
        new_use    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (cmd)
                        CMD_PUT_OVR:
                        begin
                            ram_wen = 1'b1;
                            if (full)
                            begin
                                rp_next = adv(rp_reg, eff_cap);
                            end
                            wp_next = adv(wp_reg, eff_cap);
                        end
                        CMD_PUT_TRY:
                        begin
                            if (full)
                            begin
                                new_status = 1'b1;
                            end
                            else
                            begin
                                ram_wen = 1'b1;
                                wp_next = adv(wp_reg, eff_cap);
                            end
                        end
                        CMD_GET:
                        begin
                            if (empty)
                            begin
                                new_status = 1'b1;
                            end
                            else
                            begin
                                ram_ren = 1'b1;
                                new_use = 1'b1;
                                rp_next = adv(rp_reg, eff_cap);
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (empty || (peek_count > occ_now))
                            begin
                                new_status = 1'b1;
                            end
                            else if (peek_count != '0)
                            begin
                                ram_ren   = 1'b1;
                                new_use   = 1'b1;
                                new_last  = (peek_count == CNT_W'(1));
                                pos_next  = adv(rp_reg, eff_cap);
                                left_next = peek_count - 1'b1;
                                if (peek_count != CNT_W'(1))
                                begin
                                    state_next = ST_PEEK;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            wp_next = '0;
                            rp_next = '0;
                        end
                        default:
                        begin
                            new_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_PEEK:
            begin
                if (s1_free)
                begin
                    load      = 1'b1;
                    ram_ren   = 1'b1;
                    ram_raddr = pos_reg;
                    new_use   = 1'b1;
                    new_last  = (left_reg == CNT_W'(1));
                    pos_next  = adv(pos_reg, eff_cap);
                    left_next = left_reg - 1'b1;
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Capacity write also empties the ring
        if (cfg_wen)
        begin
            cap_next = cfg_wdata;
            wp_next  = '0;
            rp_next  = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_W'(15);
            wp_reg    <= '0;
            rp_reg    <= '0;
            pos_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
        end
    end

    // Result stage, in step with the RAM read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (load)
        begin
            s1_reg.valid   <= 1'b1;
            s1_reg.status  <= new_status;
            s1_reg.last    <= new_last;
            s1_reg.occ     <= occ_fn(wp_next, rp_next, eff_cap);
            s1_reg.use_ram <= new_use;
        end
        else if (s1_adv)
        begin
            s1_reg.valid <= 1'b0;
        end
    end

    assign s1_res = s1_reg;

`ifndef SYNTHESIS
    a_peek_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PEEK) |-> (left_reg != '0))
        else $error("peek sequencer running with no bytes left");

    a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ren |-> (!s1_reg.valid || s1_adv))
        else $error("RAM read issued while the held result is stalled");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= eff_cap) && (rp_reg <= eff_cap))
        else $error("ring position beyond effective capacity");

    a_peek_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && new_last && (state_reg == ST_PEEK)) |=> (state_reg == ST_IDLE))
        else $error("peek sequencer did not return to idle after last byte");
`endif

endmodule

@@ src/brf_out_stage.sv @@
// ============================================================================
// brf_out_stage
// Output register: takes the held result and RAM byte, presents the item.
// ============================================================================
module brf_out_stage import brf_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  res_t                s1_res,
    input  logic [BYTE_W-1:0]   ram_rdata,
    output logic                s1_adv,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_status,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                out_last,
    output logic [OCC_W-1:0]    out_occ
);

    logic               valid_reg;
    logic               status_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;
    logic [OCC_W-1:0]   occ_reg;

    // Move the held result forward when the register is free or draining
    assign s1_adv = s1_res.valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg <= s1_res.status;
            byte_reg   <= s1_res.use_ram ? ram_rdata : '0;
            last_reg   <= s1_res.last;
            occ_reg    <= s1_res.occ;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;
    assign out_occ    = occ_reg;

endmodule

@@ bench/byte_ring_fifo_with_peek_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// byte_ring_fifo_with_peek_test
// Self-checking bench for the byte ring FIFO: a directed table covering the
// empty, full, wrap, refusal and peek corner cases, then random command
// phases at several capacities. Every command is run through a local FIFO
// model, and each output item is checked against the oldest expected item.
// ============================================================================
module byte_ring_fifo_with_peek_test;
    import brf_pkg::*;

    localparam int                LIMIT_CYCLES = 400000;
    localparam int                SETTLE       = 4;     // result latency plus margin
    localparam int                PHASE_ITEMS  = 40;
    localparam int                HOLD_CYCLES  = 80;
    localparam logic [CMD_W-1:0]  CMD_BAD_LO   = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_BAD_HI   = 3'd7;
    localparam logic              ST_OK        = 1'b0;
    localparam logic              ST_REFUSED   = 1'b1;

    typedef enum logic { ROW_ITEM, ROW_CAP } row_kind_t;

    // One row of the directed table; for ROW_CAP, count holds the capacity
    typedef struct {
        row_kind_t          kind;
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  wbyte;
        logic [CNT_W-1:0]   count;
        bit                 known;
        logic               status;
        logic [OCC_W-1:0]   occ;
    } stim_row_t;

    typedef struct {
        logic               status;
        logic [BYTE_W-1:0]  rbyte;
        logic               last;
        logic [OCC_W-1:0]   occ;
    } fifo_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic [CAP_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;    // cmd[2:0], write_byte[10:3], peek_count[14:11]
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;    // read_byte[7:0], occupancy[11:8]
    logic               m_tuser;    // status
    logic               m_tlast;

    // FIFO model state
    logic [BYTE_W-1:0]  ring_mem [16];
    logic [3:0]         wr_pos;
    logic [3:0]         rd_pos;
    logic [CAP_W-1:0]   cap_reg;

    fifo_result_t       awaited_results[$];
    stim_row_t          stim_rows[$];
    int                 mismatch_count;
    int                 cycle_count;
    bit                 calm;
    bit                 hold_long;

    byte_ring_fifo_with_peek u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // FIFO model
    // ------------------------------------------------------------------------
    function automatic logic [3:0] next_pos(input logic [3:0] p);
        return (p >= cap_reg) ? 4'd0 : p + 4'd1;
    endfunction

    function automatic bit ring_full();
        return next_pos(wr_pos) == rd_pos;
    endfunction

    function automatic int fill_level();
        if (ring_full())
            return int'(cap_reg);
        if (wr_pos >= rd_pos)
            return int'(wr_pos) - int'(rd_pos);
        return int'(cap_reg) + 1 + int'(wr_pos) - int'(rd_pos);
    endfunction

    function automatic void queue_result(input logic st, input logic [7:0] b,
                                         input logic lst);
        fifo_result_t r;
        r.status = st;
        r.rbyte  = b;
        r.last   = lst;
        r.occ    = OCC_W'(fill_level());
        awaited_results.push_back(r);
    endfunction

    // Applies one command to the model and queues the items it yields
    function automatic void fifo_predict(input logic [CMD_W-1:0] cmd,
                                         input logic [7:0] wb,
                                         input logic [3:0] n);
        logic [3:0] p;
        logic [7:0] b;
        case (cmd)
            CMD_PUT_OVR:
            begin
                ring_mem[wr_pos] = wb;
                if (ring_full())
                    rd_pos = next_pos(rd_pos);
                wr_pos = next_pos(wr_pos);
                queue_result(ST_OK, 8'd0, 1'b1);
            end
            CMD_PUT_TRY:
            begin
                if (ring_full())
                    queue_result(ST_REFUSED, 8'd0, 1'b1);
                else
                begin
                    ring_mem[wr_pos] = wb;
                    wr_pos = next_pos(wr_pos);
                    queue_result(ST_OK, 8'd0, 1'b1);
                end
            end
            CMD_GET:
            begin
                if (wr_pos == rd_pos)
                    queue_result(ST_REFUSED, 8'd0, 1'b1);
                else
                begin
                    b = ring_mem[rd_pos];
                    rd_pos = next_pos(rd_pos);
                    queue_result(ST_OK, b, 1'b1);
                end
            end
            CMD_PEEK:
            begin
                if (wr_pos == rd_pos || int'(n) > fill_level())
                    queue_result(ST_REFUSED, 8'd0, 1'b1);
                else if (n == 4'd0)
                    queue_result(ST_OK, 8'd0, 1'b1);
                else
                begin
                    p = rd_pos;
                    for (int i = 0; i < int'(n); i++)
                    begin
                        queue_result(ST_OK, ring_mem[p], (i + 1 == int'(n)));
                        p = next_pos(p);
                    end
                end
            end
            CMD_CLEAR:
            begin
                wr_pos = 4'd0;
                rd_pos = 4'd0;
                queue_result(ST_OK, 8'd0, 1'b1);
            end
            default:
                queue_result(ST_REFUSED, 8'd0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one item and hold it until accepted; returns with s_tvalid high
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [7:0] wb,
                             input logic [3:0] n);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, n, wb, cmd};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_input(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Capacity write: only with the block idle; it also empties the ring
    task automatic load_capacity(input logic [CAP_W-1:0] value);
        wait_until_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        cap_reg = value;
        wr_pos  = 4'd0;
        rd_pos  = 4'd0;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [CMD_W-1:0] cmd,
                           input logic [7:0] wb, input logic [3:0] n,
                           input bit known, input logic st, input logic [3:0] occ);
        stim_row_t r;
        r.kind   = kind;
        r.cmd    = cmd;
        r.wbyte  = wb;
        r.count  = n;
        r.known  = known;
        r.status = st;
        r.occ    = occ;
        stim_rows.push_back(r);
    endtask

    // Random commands, weighted toward puts by put_weight (percent)
    task automatic run_random_phase(input int items, input int put_weight);
        logic [CMD_W-1:0] cmd;
        logic [3:0]       n;
        int               r;
        for (int k = 0; k < items; k++)
        begin
            if (!calm && $urandom_range(0, 4) == 0)
                pause_input($urandom_range(1, 12));
            r = $urandom_range(0, 99);
            n = CNT_W'($urandom_range(0, 15));
            if (r < put_weight)
                cmd = $urandom_range(0, 1) ? CMD_PUT_TRY : CMD_PUT_OVR;
            else if (r < put_weight + 20)
                cmd = CMD_GET;
            else if (r < 97)
            begin
                cmd = CMD_PEEK;
                if ($urandom_range(0, 4) != 0)
                    n = CNT_W'($urandom_range(0, fill_level()));
            end
            else if (r < 99)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
            push_item(cmd, BYTE_W'($urandom_range(0, 255)), n);
            fifo_predict(cmd, s_tdata[10:3], n);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int base;
        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        calm           = 1'b0;
        hold_long      = 1'b0;
        cap_reg        = 4'd15;
        wr_pos         = 4'd0;
        rd_pos         = 4'd0;

        // Directed table: empty ring at reset capacity 15
        add_row(ROW_ITEM, CMD_GET,     8'h00, 4'd0,  1, ST_REFUSED, 4'd0);
        add_row(ROW_ITEM, CMD_PEEK,    8'h00, 4'd0,  1, ST_REFUSED, 4'd0);
        add_row(ROW_ITEM, CMD_PUT_TRY, 8'h00, 4'd0,  1, ST_OK,      4'd1);
        add_row(ROW_ITEM, CMD_PUT_OVR, 8'hFF, 4'd0,  1, ST_OK,      4'd2);
        add_row(ROW_ITEM, CMD_PEEK,    8'h00, 4'd2,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_PEEK,    8'h00, 4'd0,  1, ST_OK,      4'd2);
        add_row(ROW_ITEM, CMD_PEEK,    8'h00, 4'd3,  1, ST_REFUSED, 4'd2);
        add_row(ROW_ITEM, CMD_GET,     8'h00, 4'd0,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_GET,     8'h00, 4'd0,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_BAD_LO,  8'h00, 4'd0,  1, ST_REFUSED, 4'd0);
        add_row(ROW_ITEM, CMD_BAD_HI,  8'hFF, 4'd15, 1, ST_REFUSED, 4'd0);
        // Small ring: full, refused put, overwrite of the oldest byte, wrap
        add_row(ROW_CAP,  CMD_CLEAR,   8'h00, 4'd2,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_PUT_TRY, 8'h11, 4'd0,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_PUT_TRY, 8'h22, 4'd0,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_PUT_TRY, 8'h33, 4'd0,  1, ST_REFUSED, 4'd2);
        add_row(ROW_ITEM, CMD_PUT_OVR, 8'h44, 4'd0,  1, ST_OK,      4'd2);
        add_row(ROW_ITEM, CMD_PEEK,    8'h00, 4'd2,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_PEEK,    8'h00, 4'd15, 1, ST_REFUSED, 4'd2);
        add_row(ROW_ITEM, CMD_CLEAR,   8'h00, 4'd0,  1, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_GET,     8'h00, 4'd0,  1, ST_REFUSED, 4'd0);
        // Zero capacity: single slot that is both empty and full
        add_row(ROW_CAP,  CMD_CLEAR,   8'h00, 4'd0,  0, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_PUT_OVR, 8'h5A, 4'd0,  1, ST_OK,      4'd0);
        add_row(ROW_ITEM, CMD_PUT_TRY, 8'hA5, 4'd0,  1, ST_REFUSED, 4'd0);
        add_row(ROW_ITEM, CMD_GET,     8'h00, 4'd0,  1, ST_REFUSED, 4'd0);
        add_row(ROW_ITEM, CMD_PEEK,    8'h00, 4'd1,  1, ST_REFUSED, 4'd0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CAP)
                load_capacity(stim_rows[i].count);
            else
            begin
                push_item(stim_rows[i].cmd, stim_rows[i].wbyte, stim_rows[i].count);
                base = awaited_results.size();
                fifo_predict(stim_rows[i].cmd, stim_rows[i].wbyte, stim_rows[i].count);
                if (stim_rows[i].known)
                begin
                    awaited_results[base].status = stim_rows[i].status;
                    awaited_results[base].rbyte  = 8'd0;
                    awaited_results[base].last   = 1'b1;
                    awaited_results[base].occ    = stim_rows[i].occ;
                end
            end
        end

        // Random phases at the extremes and in between
        load_capacity(4'd1);
        run_random_phase(PHASE_ITEMS, 50);
        load_capacity(4'd15);
        run_random_phase(PHASE_ITEMS, 70);
        // Long output stall while input keeps coming: block must back up
        load_capacity(CAP_W'($urandom_range(3, 14)));
        hold_long = 1'b1;
        run_random_phase(PHASE_ITEMS, 70);
        load_capacity(CAP_W'($urandom_range(1, 15)));
        run_random_phase(PHASE_ITEMS, 35);
        load_capacity(4'd15);
        run_random_phase(PHASE_ITEMS, 70);
        // Final stretch at full rate on both sides
        load_capacity(4'd4);
        calm = 1'b1;
        run_random_phase(PHASE_ITEMS, 50);

        wait_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS byte_ring_fifo_with_peek");
        else
            $display("FAIL byte_ring_fifo_with_peek");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            if (hold_long && !calm)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Result checker: each accepted item against the oldest expectation
    always @(posedge clk)
    begin
        fifo_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("item with nothing expected: status %0d byte %0h occupancy %0d",
                       m_tuser, m_tdata[7:0], m_tdata[11:8]);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[7:0] !== want.rbyte)
                begin
                    $error("read_byte: expected %0h, got %0h", want.rbyte, m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[11:8] !== want.occ)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occ, m_tdata[11:8]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("FAIL byte_ring_fifo_with_peek");
                $finish;
            end
        end
    end

endmodule
